// ===== rtl/roller_table_video_fetch_top_macros.svh =====
// Assertion macros shared by the video fetch checker.
// No dependencies; included by rtvf_checker.sv.
`ifndef ROLLER_TABLE_VIDEO_FETCH_TOP_MACROS_SVH
`define ROLLER_TABLE_VIDEO_FETCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RTVF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RTVF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rtvf_pkg.sv =====
// Package for the line-table video fetch engine: widths, codes, result type
// and the descriptor decode function. No dependencies.
package rtvf_pkg;

   localparam int LINES_PER_FRAME_DEF = 256;
   localparam int BYTES_PER_LINE_DEF  = 90;
   localparam int BYTE_STRIDE_DEF     = 8;

   localparam int ADDR_W      = 19;
   localparam int DATA_W      = 16;
   localparam int PIXEL_W     = 8;
   localparam int CTRL_W      = 8;
   localparam int START_W     = 8;
   localparam int OFFSET_W    = 9;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 19;

   localparam int CTRL_INVERT_BIT = 7;
   localparam int CTRL_ENABLE_BIT = 6;

   localparam logic [CSR_INDEX_W-1:0] REG_VIDEO_CONTROL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_BASE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_START   = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_FRAME_START = 2'd0,
      KIND_DESCRIPTOR  = 2'd1,
      KIND_PIXEL_BYTE  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  read_address;
      logic               read_valid;
      logic               read_is_word;
      logic [PIXEL_W-1:0] pixel_group;
      logic               pixels_valid;
      logic               line_done;
      logic               frame_done;
      logic               border_pen;
   } rsp_type;

   // Bank-scattered line address: bits 15..13 and 12..3 move up one place.
   function automatic logic [ADDR_W-1:0] decode_line(input logic [DATA_W-1:0] d);
      return {2'b00, d[15:13], d[12:3], 1'b0, d[2:0]};
   endfunction

endpackage

// ===== rtl/rtvf_engine.sv =====
// Fetch engine: configuration registers, line/byte/table counters and the
// single-pass step logic for one beat. Depends on rtvf_pkg.
module rtvf_engine #(
   parameter int LINES_PER_FRAME = 256,
   parameter int BYTES_PER_LINE  = 90,
   parameter int BYTE_STRIDE     = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rtvf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rtvf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            step_valid,
   input  logic [rtvf_pkg::KIND_W-1:0]      step_kind,
   input  logic [rtvf_pkg::DATA_W-1:0]      step_data,
   output rtvf_pkg::rsp_type               step_result
);
   import rtvf_pkg::*;

   localparam int LINE_W = $clog2(LINES_PER_FRAME + 1);
   localparam int BYTE_W = $clog2(BYTES_PER_LINE + 1);

   logic [CTRL_W-1:0]   ctrl_ff, ctrl_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0]   pointer_ff, pointer_in;

   logic                enabled;
   logic                invert;
   logic                finished;
   logic [LINE_W-1:0]   line_next;
   logic [BYTE_W-1:0]   byte_next;
   logic [OFFSET_W-1:0] offset_first;
   logic [OFFSET_W-1:0] offset_next;
   logic [ADDR_W-1:0]   pointer_desc;
   logic [ADDR_W-1:0]   pointer_next;
   logic [ADDR_W-1:0]   table_first;
   logic [ADDR_W-1:0]   table_next;
   rsp_type             res;

   assign enabled      = ctrl_ff[CTRL_ENABLE_BIT];
   assign invert       = ctrl_ff[CTRL_INVERT_BIT];
   assign finished     = (line_ff >= LINE_W'(LINES_PER_FRAME));
   assign line_next    = line_ff + LINE_W'(1);
   assign byte_next    = byte_ff + BYTE_W'(1);
   assign offset_first = {start_ff, 1'b0};
   assign offset_next  = offset_ff + OFFSET_W'(2);
   assign pointer_desc = decode_line(step_data);
   assign pointer_next = pointer_ff + ADDR_W'(BYTE_STRIDE);
   assign table_first  = base_ff + ADDR_W'(offset_first);
   assign table_next   = base_ff + ADDR_W'(offset_next);

   always_comb begin
      ctrl_in  = ctrl_ff;
      base_in  = base_ff;
      start_in = start_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_VIDEO_CONTROL: ctrl_in  = csr_wdata[CTRL_W-1:0];
            REG_TABLE_BASE:    base_in  = csr_wdata[ADDR_W-1:0];
            REG_TABLE_START:   start_in = csr_wdata[START_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      line_in    = line_ff;
      byte_in    = byte_ff;
      offset_in  = offset_ff;
      pointer_in = pointer_ff;
      res            = '0;
      res.border_pen = invert;
      case (kind_type'(step_kind))
         KIND_FRAME_START: begin
            offset_in = offset_first;
            line_in   = '0;
            byte_in   = '0;
            if (enabled) begin
               res.read_address = table_first;
               res.read_valid   = 1'b1;
               res.read_is_word = 1'b1;
            end else begin
               res.frame_done = 1'b1;
            end
         end
         KIND_DESCRIPTOR: begin
            if (!enabled || finished) begin
               res.frame_done = 1'b1;
            end else begin
               pointer_in       = pointer_desc;
               byte_in          = '0;
               res.read_address = pointer_desc;
               res.read_valid   = 1'b1;
            end
         end
         KIND_PIXEL_BYTE: begin
            if (!enabled || finished) begin
               res.frame_done = 1'b1;
            end else begin
               res.pixel_group  = step_data[PIXEL_W-1:0] ^ {PIXEL_W{invert}};
               res.pixels_valid = 1'b1;
               pointer_in       = pointer_next;
               if (byte_next >= BYTE_W'(BYTES_PER_LINE)) begin
                  res.line_done = 1'b1;
                  byte_in       = '0;
                  offset_in     = offset_next;
                  line_in       = line_next;
                  if (line_next >= LINE_W'(LINES_PER_FRAME)) begin
                     res.frame_done = 1'b1;
                  end else begin
                     res.read_address = table_next;
                     res.read_valid   = 1'b1;
                     res.read_is_word = 1'b1;
                  end
               end else begin
                  byte_in          = byte_next;
                  res.read_address = pointer_next;
                  res.read_valid   = 1'b1;
               end
            end
         end
         default: begin
            res.frame_done = !enabled || finished;
         end
      endcase
   end

   assign step_result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         base_ff    <= '0;
         start_ff   <= '0;
         line_ff    <= '0;
         byte_ff    <= '0;
         offset_ff  <= '0;
         pointer_ff <= '0;
      end else begin
         ctrl_ff  <= ctrl_in;
         base_ff  <= base_in;
         start_ff <= start_in;
         if (step_valid) begin
            line_ff    <= line_in;
            byte_ff    <= byte_in;
            offset_ff  <= offset_in;
            pointer_ff <= pointer_in;
         end
      end
   end

endmodule

// ===== rtl/roller_table_video_fetch_top.sv =====
// Top level of the line-table video fetch engine: input register, engine
// and result register. Depends on rtvf_pkg and rtvf_engine.
//
// One beat in, one beat out: every request beat yields exactly one response
// beat, via the input register and then the result register. A new beat is
// taken in every clock cycle while req_ready is high; the pace is set by
// the single pass of the engine between the input and result registers.
// req_ready drops only while both registers hold beats and rsp_ready is
// low. Configuration writes take effect in the next cycle; the user must
// make them only while no beat is in flight; the block does not enforce it.
module roller_table_video_fetch_top #(
   parameter int LINES_PER_FRAME = rtvf_pkg::LINES_PER_FRAME_DEF,
   parameter int BYTES_PER_LINE  = rtvf_pkg::BYTES_PER_LINE_DEF,
   parameter int BYTE_STRIDE     = rtvf_pkg::BYTE_STRIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rtvf_pkg::KIND_W-1:0]      req_kind,
   input  logic [rtvf_pkg::DATA_W-1:0]      req_mem_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rtvf_pkg::ADDR_W-1:0]      rsp_read_address,
   output logic                            rsp_read_valid,
   output logic                            rsp_read_is_word,
   output logic [rtvf_pkg::PIXEL_W-1:0]     rsp_pixel_group,
   output logic                            rsp_pixels_valid,
   output logic                            rsp_line_done,
   output logic                            rsp_frame_done,
   output logic                            rsp_border_pen,
   input  logic                            csr_write_enable,
   input  logic [rtvf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rtvf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rtvf_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [KIND_W-1:0] in_kind_ff, in_kind_in;
   logic [DATA_W-1:0] in_data_ff, in_data_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              advance;
   logic              req_take;
   rsp_type           step_result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   rtvf_engine #(
      .LINES_PER_FRAME (LINES_PER_FRAME),
      .BYTES_PER_LINE  (BYTES_PER_LINE),
      .BYTE_STRIDE     (BYTE_STRIDE)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .step_valid       (advance),
      .step_kind        (in_kind_ff),
      .step_data        (in_data_ff),
      .step_result      (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_kind_in   = in_kind_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_kind;
         in_data_in  = req_mem_data;
      end
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_data_ff <= in_data_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_address = out_ff.read_address;
   assign rsp_read_valid   = out_ff.read_valid;
   assign rsp_read_is_word = out_ff.read_is_word;
   assign rsp_pixel_group  = out_ff.pixel_group;
   assign rsp_pixels_valid = out_ff.pixels_valid;
   assign rsp_line_done    = out_ff.line_done;
   assign rsp_frame_done   = out_ff.frame_done;
   assign rsp_border_pen   = out_ff.border_pen;

endmodule

// ===== rtl/rtvf_checker.sv =====
// Port-level checker for the video fetch top level, bound to it below.
// Depends on rtvf_pkg and roller_table_video_fetch_top_macros.svh.
`include "roller_table_video_fetch_top_macros.svh"

module rtvf_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [rtvf_pkg::ADDR_W-1:0]      rsp_read_address,
   input  logic                            rsp_read_valid,
   input  logic                            rsp_read_is_word,
   input  logic [rtvf_pkg::PIXEL_W-1:0]     rsp_pixel_group,
   input  logic                            rsp_pixels_valid,
   input  logic                            rsp_line_done,
   input  logic                            rsp_frame_done
);
   import rtvf_pkg::*;

   `RTVF_ASSERT_NOW(a_idle_read_zero, rsp_valid && !rsp_read_valid,
      rsp_read_address == '0 && !rsp_read_is_word, "read fields set without request")

   `RTVF_ASSERT_NOW(a_line_done_pixels, rsp_valid && rsp_line_done,
      rsp_pixels_valid && (rsp_read_is_word || rsp_frame_done),
      "line end without pixels or next descriptor request")

   `RTVF_ASSERT_NOW(a_request_not_done, rsp_valid && rsp_read_valid,
      !rsp_frame_done && (rsp_pixels_valid || rsp_line_done == 1'b0),
      "request issued on a finished frame")

   `RTVF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_read_address) && $stable(rsp_pixel_group)
      && $stable(rsp_frame_done), "stalled response beat changed")

endmodule

bind roller_table_video_fetch_top rtvf_checker u_rtvf_checker (.*);
